/* hw/rtl/sqltok_pkg.sv */
// Shared types and constants for the SQL keyword tokenizer.
`default_nettype none
package sqltok_pkg;

    localparam int KW_NUM = 34;
    localparam int KW_LEN = 10;

    // token kind codes
    localparam logic [5:0] TK_EOF    = 6'd0;
    localparam logic [5:0] TK_IDENT  = 6'd1;
    localparam logic [5:0] TK_INT    = 6'd2;
    localparam logic [5:0] TK_FLOAT  = 6'd3;
    localparam logic [5:0] TK_STRING = 6'd4;
    localparam logic [5:0] TK_LPAREN = 6'd5;
    localparam logic [5:0] TK_RPAREN = 6'd6;
    localparam logic [5:0] TK_COMMA  = 6'd7;
    localparam logic [5:0] TK_SEMI   = 6'd8;
    localparam logic [5:0] TK_DOT    = 6'd9;
    localparam logic [5:0] TK_STAR   = 6'd10;
    localparam logic [5:0] TK_EQ     = 6'd11;
    localparam logic [5:0] TK_NE     = 6'd12;
    localparam logic [5:0] TK_LT     = 6'd13;
    localparam logic [5:0] TK_LE     = 6'd14;
    localparam logic [5:0] TK_GT     = 6'd15;
    localparam logic [5:0] TK_GE     = 6'd16;
    localparam logic [5:0] TK_KW0    = 6'd17;

    // scan modes
    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_IDENT  = 3'd1;
    localparam logic [2:0] MODE_NUMBER = 3'd2;
    localparam logic [2:0] MODE_STRING = 3'd3;
    localparam logic [2:0] MODE_LT     = 3'd4;
    localparam logic [2:0] MODE_GT     = 3'd5;
    localparam logic [2:0] MODE_BANG   = 3'd6;

    typedef logic [KW_LEN*8-1:0] kw_text_t;

    // keyword spelled left-aligned, zero padded
    function automatic kw_text_t kw_text(input logic [5:0] k);
        kw_text_t t;
        t = '0;
        unique case (k)
            6'd0:  t = {"CREATE", 32'h0};
            6'd1:  t = {"TABLE", 40'h0};
            6'd2:  t = {"INSERT", 32'h0};
            6'd3:  t = {"INTO", 48'h0};
            6'd4:  t = {"VALUES", 32'h0};
            6'd5:  t = {"SELECT", 32'h0};
            6'd6:  t = {"FROM", 48'h0};
            6'd7:  t = {"WHERE", 40'h0};
            6'd8:  t = {"AND", 56'h0};
            6'd9:  t = {"OR", 64'h0};
            6'd10: t = {"UPDATE", 32'h0};
            6'd11: t = {"SET", 56'h0};
            6'd12: t = {"DELETE", 32'h0};
            6'd13: t = {"DROP", 48'h0};
            6'd14: t = {"BEGIN", 40'h0};
            6'd15: t = {"COMMIT", 32'h0};
            6'd16: t = {"ROLLBACK", 16'h0};
            6'd17: t = {"NULL", 48'h0};
            6'd18: t = {"NOT", 56'h0};
            6'd19: t = {"PRIMARY", 24'h0};
            6'd20: t = {"KEY", 56'h0};
            6'd21: t = {"INTEGER", 24'h0};
            6'd22: t = {"TEXT", 48'h0};
            6'd23: t = {"REAL", 48'h0};
            6'd24: t = {"BLOB", 48'h0};
            6'd25: t = {"ORDER", 40'h0};
            6'd26: t = {"BY", 64'h0};
            6'd27: t = {"ASC", 56'h0};
            6'd28: t = {"DESC", 48'h0};
            6'd29: t = {"LIMIT", 40'h0};
            6'd30: t = {"OFFSET", 32'h0};
            6'd31: t = {"IF", 64'h0};
            6'd32: t = {"EXISTS", 32'h0};
            6'd33: t = {"COLLECTION"};
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [7:0] kw_char(input logic [5:0] k, input logic [3:0] i);
        kw_text_t t;
        t = kw_text(k);
        return t[(KW_LEN-1-int'(i))*8 +: 8];
    endfunction

    function automatic logic [3:0] kw_size(input logic [5:0] k);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < KW_LEN; i++) begin
            if (kw_char(k, 4'(i)) != 8'h00) n = 4'(i + 1);
        end
        return n;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/sqltok_scan.sv */
// Front end: lexer state machine, emits up to two token records per byte.
`default_nettype none
module sqltok_scan #(
    parameter int PW = 16
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    input  wire logic [7:0]    in_byte,
    output logic               in_ready,
    output logic               push,
    output logic [1:0]         push_n,
    output logic [6+4*PW:0]    rec0,
    output logic [6+4*PW:0]    rec1,
    input  wire logic          room
);
    localparam logic [PW-1:0] PMAX = '1;
    localparam logic [PW-1:0] ONE  = PW'(1);
    localparam int KN = sqltok_pkg::KW_NUM;

    logic [2:0]    mode_reg, mode_next;
    logic          dq_reg, dq_next, esc_reg, esc_next, dot_reg, dot_next;
    logic [PW-1:0] soff_reg, soff_next, run_reg, run_next;
    logic [KN-1:0] cand_reg, cand_next;
    logic [PW-1:0] pos_reg, pos_next, line_reg, line_next, col_reg, col_next;

    function automatic logic [PW-1:0] sinc(input logic [PW-1:0] v);
        return (v == PMAX) ? v : v + ONE;
    endfunction

    // candidate filter at one character index
    function automatic logic [KN-1:0] filt(input logic [KN-1:0] c, input logic [7:0] b,
                                           input logic [PW-1:0] idx);
        logic [KN-1:0] r;
        logic [7:0] up;
        up = (b >= "a" && b <= "z") ? b - 8'd32 : b;
        r = c;
        for (int k = 0; k < KN; k++) begin
            if (idx >= PW'(sqltok_pkg::KW_LEN) ||
                sqltok_pkg::kw_char(6'(k), idx[3:0]) != up)
                r[k] = 1'b0;
        end
        return r;
    endfunction

    logic [5:0] ikind;
    always_comb begin
        ikind = sqltok_pkg::TK_IDENT;
        for (int k = KN - 1; k >= 0; k--) begin
            if (cand_reg[k] && PW'(sqltok_pkg::kw_size(6'(k))) == run_reg)
                ikind = 6'(int'(sqltok_pkg::TK_KW0) + k);
        end
    end

    logic is_dig, is_alp, is_idc;
    assign is_dig = in_byte >= "0" && in_byte <= "9";
    assign is_alp = (in_byte >= "A" && in_byte <= "Z") || (in_byte >= "a" && in_byte <= "z");
    assign is_idc = is_alp || is_dig || in_byte == "_";

    assign in_ready = room;
    logic fire;
    assign fire = in_valid && room;

    // next state and emitted records
    always_comb begin
        logic consumed;
        logic [PW-1:0] c, l, pos;
        logic [5:0] k0, k1;
        logic [PW-1:0] o0, o1, n0, n1;
        logic [1:0] n;
        mode_next = mode_reg; dq_next = dq_reg; esc_next = esc_reg; dot_next = dot_reg;
        soff_next = soff_reg; run_next = run_reg; cand_next = cand_reg;
        consumed = 1'b0; c = col_reg; l = line_reg; pos = pos_reg;
        n = 2'd0; k0 = '0; o0 = '0; n0 = '0; k1 = '0; o1 = '0; n1 = '0;
        rec0 = '0; rec1 = '0;
        unique case (mode_reg)
            sqltok_pkg::MODE_LT, sqltok_pkg::MODE_GT: begin
                n = 2'd1; o0 = soff_reg;
                if (in_byte == "=") begin
                    c = sinc(c); consumed = 1'b1; n0 = PW'(2);
                    k0 = (mode_reg == sqltok_pkg::MODE_LT) ? sqltok_pkg::TK_LE
                                                           : sqltok_pkg::TK_GE;
                end else begin
                    n0 = ONE;
                    k0 = (mode_reg == sqltok_pkg::MODE_LT) ? sqltok_pkg::TK_LT
                                                           : sqltok_pkg::TK_GT;
                end
                mode_next = sqltok_pkg::MODE_IDLE;
            end
            sqltok_pkg::MODE_BANG: begin
                if (in_byte == "=") begin
                    c = sinc(c); consumed = 1'b1; n = 2'd1;
                    k0 = sqltok_pkg::TK_NE; o0 = soff_reg; n0 = PW'(2);
                end
                mode_next = sqltok_pkg::MODE_IDLE;
            end
            sqltok_pkg::MODE_IDENT: begin
                if (is_idc) begin
                    c = sinc(c); cand_next = filt(cand_reg, in_byte, run_reg);
                    run_next = sinc(run_reg); consumed = 1'b1;
                end else begin
                    n = 2'd1; k0 = ikind; o0 = soff_reg; n0 = run_reg;
                    mode_next = sqltok_pkg::MODE_IDLE;
                end
            end
            sqltok_pkg::MODE_NUMBER: begin
                if (is_dig || in_byte == ".") begin
                    c = sinc(c);
                    if (in_byte == ".") dot_next = 1'b1;
                    run_next = sinc(run_reg); consumed = 1'b1;
                end else begin
                    n = 2'd1; o0 = soff_reg; n0 = run_reg;
                    k0 = dot_reg ? sqltok_pkg::TK_FLOAT : sqltok_pkg::TK_INT;
                    mode_next = sqltok_pkg::MODE_IDLE;
                end
            end
            sqltok_pkg::MODE_STRING: begin
                if (in_byte == 8'h00) begin
                    n = 2'd1; k0 = sqltok_pkg::TK_STRING; o0 = soff_reg; n0 = run_reg;
                    mode_next = sqltok_pkg::MODE_IDLE;
                end else if (!esc_reg && in_byte == (dq_reg ? 8'h22 : 8'h27)) begin
                    c = sinc(c); consumed = 1'b1;
                    n = 2'd1; k0 = sqltok_pkg::TK_STRING; o0 = soff_reg; n0 = run_reg;
                    mode_next = sqltok_pkg::MODE_IDLE;
                end else begin
                    c = sinc(c); run_next = sinc(run_reg); consumed = 1'b1;
                    esc_next = esc_reg ? 1'b0 : (in_byte == 8'h5c);
                end
            end
            default: mode_next = sqltok_pkg::MODE_IDLE;
        endcase
        // column and line as seen by the first token
        rec0 = {k0, o0, n0, l, c, 1'b0};
        if (!consumed) begin
            logic em;
            logic [5:0] kk;
            em = 1'b0; kk = '0;
            if (in_byte == 8'h00) begin
                em = 1'b1; kk = sqltok_pkg::TK_EOF;
            end else if (in_byte == 8'h0a) begin
                l = sinc(l); c = ONE;
            end else begin
                c = sinc(c);
                priority case (1'b1)
                    in_byte == "(": begin em = 1'b1; kk = sqltok_pkg::TK_LPAREN; end
                    in_byte == ")": begin em = 1'b1; kk = sqltok_pkg::TK_RPAREN; end
                    in_byte == ",": begin em = 1'b1; kk = sqltok_pkg::TK_COMMA; end
                    in_byte == ";": begin em = 1'b1; kk = sqltok_pkg::TK_SEMI; end
                    in_byte == ".": begin em = 1'b1; kk = sqltok_pkg::TK_DOT; end
                    in_byte == "*": begin em = 1'b1; kk = sqltok_pkg::TK_STAR; end
                    in_byte == "=": begin em = 1'b1; kk = sqltok_pkg::TK_EQ; end
                    in_byte == "<": begin mode_next = sqltok_pkg::MODE_LT; soff_next = pos; end
                    in_byte == ">": begin mode_next = sqltok_pkg::MODE_GT; soff_next = pos; end
                    in_byte == "!": begin
                        mode_next = sqltok_pkg::MODE_BANG; soff_next = pos;
                    end
                    in_byte == 8'h27 || in_byte == 8'h22: begin
                        mode_next = sqltok_pkg::MODE_STRING; dq_next = in_byte == 8'h22;
                        esc_next = 1'b0; soff_next = sinc(pos); run_next = '0;
                    end
                    is_dig: begin
                        mode_next = sqltok_pkg::MODE_NUMBER; soff_next = pos;
                        run_next = ONE; dot_next = 1'b0;
                    end
                    is_alp || in_byte == "_": begin
                        mode_next = sqltok_pkg::MODE_IDENT; soff_next = pos;
                        cand_next = filt('1, in_byte, '0); run_next = ONE;
                    end
                    default: ;
                endcase
            end
            if (em) begin
                k1 = kk; o1 = pos; n1 = (kk == sqltok_pkg::TK_EOF) ? '0 : ONE;
                if (n == 2'd0) rec0 = {k1, o1, n1, l, c, 1'b0};
                else           rec1 = {k1, o1, n1, l, c, 1'b0};
                n = n + 2'd1;
            end
        end
        // mark last token of the byte
        if (n == 2'd1) rec0[0] = 1'b1;
        if (n == 2'd2) rec1[0] = 1'b1;
        push_n = n;
        line_next = l; col_next = c;
        pos_next = (in_byte != 8'h00) ? sinc(pos_reg) : pos_reg;
        if (in_byte == 8'h00) begin
            mode_next = sqltok_pkg::MODE_IDLE; dq_next = 1'b0; esc_next = 1'b0;
            dot_next = 1'b0; soff_next = '0; run_next = '0; cand_next = '1;
            pos_next = '0; line_next = ONE; col_next = ONE;
        end
    end
    assign push = fire && push_n != 2'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= sqltok_pkg::MODE_IDLE; dq_reg <= 1'b0; esc_reg <= 1'b0;
            dot_reg <= 1'b0; soff_reg <= '0; run_reg <= '0; cand_reg <= '1;
            pos_reg <= '0; line_reg <= ONE; col_reg <= ONE;
        end else if (fire) begin
            mode_reg <= mode_next; dq_reg <= dq_next; esc_reg <= esc_next;
            dot_reg <= dot_next; soff_reg <= soff_next; run_reg <= run_next;
            cand_reg <= cand_next; pos_reg <= pos_next; line_reg <= line_next;
            col_reg <= col_next;
        end
    end

    a_line_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        line_reg != '0) else $error("line count reached zero");
    a_col_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg != '0) else $error("column count reached zero");
    a_eof_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_byte == 8'h00 |=> mode_reg == sqltok_pkg::MODE_IDLE && pos_reg == '0)
        else $error("end byte did not reset scanner");
endmodule
`default_nettype wire

/* hw/rtl/sqltok_queue.sv */
// Token queue between scanner and output: two pushes, one pop per cycle; a pop waits for out_ready.
`default_nettype none
module sqltok_queue #(
    parameter int W = 71
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire logic [1:0]   push_n,
    input  wire logic [W-1:0] d0,
    input  wire logic [W-1:0] d1,
    output logic              room,
    output logic              out_valid,
    output logic [W-1:0]      out_data,
    input  wire logic         out_ready
);
    localparam int DEPTH = 4;
    logic [W-1:0] mem [DEPTH];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic pop;

    assign pop = out_valid && out_ready;
    assign out_valid = cnt_reg != 3'd0;
    assign out_data = mem[rp_reg];
    // need two free slots regardless of pop
    assign room = cnt_reg <= 3'd2;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wp_reg] <= d0;
            if (push_n == 2'd2) mem[wp_reg + 2'd1] <= d1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + push_n;
            if (pop) rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + (push ? {1'b0, push_n} : 3'd0) - {2'b0, pop};
        end
    end

    a_no_over: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 3'(DEPTH)) else $error("queue overflow");
    a_cnt_track: assert property (@(posedge aclk) disable iff (!aresetn)
        !push && !pop |=> $stable(cnt_reg)) else $error("queue count drift");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("waiting item changed");
endmodule
`default_nettype wire

/* hw/rtl/sql_keyword_tokenizer_top.sv */
// Top level of the SQL keyword tokenizer.
// Output: a token is queued when the byte that completes it is taken, and waits behind earlier tokens.
// Throughput: one byte per cycle; up to two tokens per byte drain one per cycle while m_ready is high
// through a four-entry queue, so input stalls only when the queue cannot take two.
// Reset: synchronous active-low aresetn; line and column return to one, queue empties.
`default_nettype none
module sql_keyword_tokenizer_top #(
    parameter int POSITION_BITS = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [7:0]               s_text_byte,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [5:0]                    m_token_kind,
    output logic [POSITION_BITS-1:0]      m_token_offset,
    output logic [POSITION_BITS-1:0]      m_token_length,
    output logic [POSITION_BITS-1:0]      m_line_number,
    output logic [POSITION_BITS-1:0]      m_column_number,
    output logic                          m_last_of_run
);
    localparam int W = 7 + 4 * POSITION_BITS;
    logic push, room;
    logic [1:0] push_n;
    logic [W-1:0] r0, r1, q;

    sqltok_scan #(.PW(POSITION_BITS)) u_scan (
        .aclk, .aresetn, .in_valid(s_valid), .in_byte(s_text_byte), .in_ready(s_ready),
        .push, .push_n, .rec0(r0), .rec1(r1), .room
    );

    sqltok_queue #(.W(W)) u_queue (
        .aclk, .aresetn, .push, .push_n, .d0(r0), .d1(r1), .room,
        .out_valid(m_valid), .out_data(q), .out_ready(m_ready)
    );

    assign {m_token_kind, m_token_offset, m_token_length, m_line_number,
            m_column_number, m_last_of_run} = q;
endmodule
`default_nettype wire
